// ===== sv/acq_pkg.sv =====
package acq_pkg;

   // queue geometry
   localparam int QUEUE_DEPTH  = 16;
   localparam int COMMAND_BITS = 64;
   localparam int PTR_BITS     = $clog2(QUEUE_DEPTH);
   localparam int COUNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // request kinds
   typedef enum logic [3:0] {
      K_QUEUE     = 4'd0,
      K_ARM       = 4'd1,
      K_START     = 4'd2,
      K_TIMED     = 4'd3,
      K_CLEAR     = 4'd4,
      K_ESTOP     = 4'd5,
      K_CLR_FAULT = 4'd6,
      K_DONE      = 4'd7,
      K_FAULT     = 4'd8,
      K_TICK      = 4'd9
   } kind_type;

   // operation status codes
   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_FULL    = 3'd1,
      ST_EMPTY   = 3'd2,
      ST_INVALID = 3'd3,
      ST_EXPIRED = 3'd4
   } status_type;

   // controller modes
   typedef enum logic [2:0] {
      M_IDLE    = 3'd0,
      M_ARMED   = 3'd1,
      M_RUNNING = 3'd2,
      M_FAULT   = 3'd3,
      M_ESTOP   = 3'd4
   } mode_type;

   // command store ports
   typedef struct packed {
      logic                    en;
      logic [PTR_BITS-1:0]     addr;
      logic [COMMAND_BITS-1:0] data;
   } store_wr_type;

   typedef struct packed {
      logic                en;
      logic [PTR_BITS-1:0] addr;
   } store_rd_type;

endpackage

// ===== sv/acq_req_if.sv =====
interface acq_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  kind;
   logic [63:0] command_word;
   logic [31:0] target_tick;
   logic [31:0] now_tick;

   modport source (output valid, kind, command_word, target_tick, now_tick, input ready);
   modport sink (input valid, kind, command_word, target_tick, now_tick, output ready);
endinterface

// ===== sv/acq_rsp_if.sv =====
interface acq_rsp_if;
   logic        valid;
   logic        ready;
   logic        command_valid;
   logic [63:0] command_out;
   logic        hard_stop;
   logic        status_valid;
   logic [2:0]  status;
   logic [2:0]  controller_state;
   logic [4:0]  queue_count;
   logic        last;

   modport source (output valid, command_valid, command_out, hard_stop, status_valid,
                   status, controller_state, queue_count, last, input ready);
   modport sink (input valid, command_valid, command_out, hard_stop, status_valid,
                 status, controller_state, queue_count, last, output ready);
endinterface

// ===== sv/acq_store.sv =====
module acq_store (
   input  logic                                clock,
   input  acq_pkg::store_wr_type               wr,
   input  acq_pkg::store_rd_type               rd,
   output logic [acq_pkg::COMMAND_BITS-1:0]    rd_data
);

   logic [acq_pkg::COMMAND_BITS-1:0] mem [acq_pkg::QUEUE_DEPTH];
   logic [acq_pkg::COMMAND_BITS-1:0] rd_data_ff;

   // one write port, one registered read port; read data holds when idle
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/armed_command_queue_unit.sv =====
// Armed command queue: motor command FIFO behind a five-state controller.
// Requests arrive on req_ch (valid/ready); each request yields one or more
// results on rsp_ch, the final one flagged by last.
// For most requests the result is registered and shows up on rsp_ch
// the cycle after the request is taken.
// A start, or a timed start firing on a tick while armed, streams every
// queued command from the command store: first the store read of the
// first command, then one command per cycle while the receiver takes
// results, then the ok status; only then is the next request taken. The
// single read port of the command store sets that rate.
// A request is taken only while no flush is in progress and the result
// register is empty or being emptied in the same cycle; when the receiver
// stalls, the current result holds and req_ch.ready drops.
// Reset (synchronous, active high) empties the queue, returns to idle,
// drops any waiting timed start and empties the result register. The
// command store itself is not cleared; only counted entries are read.
module armed_command_queue_unit (
   input logic       clock,
   input logic       reset,
   acq_req_if.sink   req_ch,
   acq_rsp_if.source rsp_ch
);

   localparam logic [acq_pkg::PTR_BITS-1:0] LastPtr =
      acq_pkg::PTR_BITS'(acq_pkg::QUEUE_DEPTH - 1);
   localparam logic [acq_pkg::COUNT_BITS-1:0] FullCount =
      acq_pkg::COUNT_BITS'(acq_pkg::QUEUE_DEPTH);

   typedef enum logic [1:0] {
      S_IDLE,
      S_FLUSH,
      S_STATUS
   } state_type;

   state_type                        state_ff, state_in;
   acq_pkg::mode_type                mode_ff, mode_in;
   logic [acq_pkg::PTR_BITS-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [acq_pkg::PTR_BITS-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [acq_pkg::COUNT_BITS-1:0]   count_ff, count_in;
   logic                             waiting_ff, waiting_in;
   logic [31:0]                      target_ff, target_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             rsp_cmd_valid_ff, rsp_cmd_valid_in;
   logic [63:0]                      rsp_cmd_ff, rsp_cmd_in;
   logic                             rsp_hard_ff, rsp_hard_in;
   logic                             rsp_stat_valid_ff, rsp_stat_valid_in;
   acq_pkg::status_type              rsp_status_ff, rsp_status_in;
   acq_pkg::mode_type                rsp_mode_ff, rsp_mode_in;
   logic [4:0]                       rsp_count_ff, rsp_count_in;
   logic                             rsp_last_ff, rsp_last_in;

   acq_pkg::store_wr_type            store_wr;
   acq_pkg::store_rd_type            store_rd;
   logic [acq_pkg::COMMAND_BITS-1:0] store_data;

   logic                             load;
   logic                             accept;
   logic [31:0]                      start_diff;
   logic [31:0]                      due_diff;
   logic                             due;

   // emit fields for this cycle
   logic                             o_load;
   logic                             o_cmd_valid;
   logic [63:0]                      o_cmd;
   logic                             o_hard;
   logic                             o_stat_valid;
   acq_pkg::status_type              o_status;
   logic                             o_last;

   function automatic logic [acq_pkg::PTR_BITS-1:0] ptr_next(
      input logic [acq_pkg::PTR_BITS-1:0] p
   );
      ptr_next = (p == LastPtr) ? '0 : p + 1'b1;
   endfunction

   acq_store u_store (
      .clock   (clock),
      .wr      (store_wr),
      .rd      (store_rd),
      .rd_data (store_data)
   );

   // handshake
   assign load          = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready  = (state_ff == S_IDLE) && load;
   assign accept        = req_ch.valid && req_ch.ready;

   // signed tick distances
   assign start_diff = req_ch.target_tick - req_ch.now_tick;
   assign due_diff   = target_ff - req_ch.now_tick;
   assign due        = (due_diff == 32'd0) || due_diff[31];

   // controller and flush sequencer
   always_comb begin
      state_in   = state_ff;
      mode_in    = mode_ff;
      rd_ptr_in  = rd_ptr_ff;
      wr_ptr_in  = wr_ptr_ff;
      count_in   = count_ff;
      waiting_in = waiting_ff;
      target_in  = target_ff;

      store_wr.en   = 1'b0;
      store_wr.addr = wr_ptr_ff;
      store_wr.data = req_ch.command_word[acq_pkg::COMMAND_BITS-1:0];
      store_rd.en   = 1'b0;
      store_rd.addr = rd_ptr_ff;

      o_load       = 1'b0;
      o_cmd_valid  = 1'b0;
      o_cmd        = '0;
      o_hard       = 1'b0;
      o_stat_valid = 1'b0;
      o_status     = acq_pkg::ST_OK;
      o_last       = 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               o_load = 1'b1;
               case (req_ch.kind)
                  acq_pkg::K_QUEUE: begin
                     o_stat_valid = 1'b1;
                     if (mode_ff != acq_pkg::M_IDLE) begin
                        o_status = acq_pkg::ST_INVALID;
                     end else if (count_ff >= FullCount) begin
                        o_status = acq_pkg::ST_FULL;
                     end else begin
                        store_wr.en = 1'b1;
                        wr_ptr_in   = ptr_next(wr_ptr_ff);
                        count_in    = count_ff + 1'b1;
                     end
                  end
                  acq_pkg::K_ARM: begin
                     o_stat_valid = 1'b1;
                     if (mode_ff != acq_pkg::M_IDLE) begin
                        o_status = acq_pkg::ST_INVALID;
                     end else if (count_ff == '0) begin
                        o_status = acq_pkg::ST_EMPTY;
                     end else begin
                        mode_in = acq_pkg::M_ARMED;
                     end
                  end
                  acq_pkg::K_START: begin
                     if (mode_ff != acq_pkg::M_ARMED) begin
                        o_stat_valid = 1'b1;
                        o_status     = acq_pkg::ST_INVALID;
                     end else if (count_ff != '0) begin
                        o_load         = 1'b0;
                        state_in       = S_FLUSH;
                        store_rd.en    = 1'b1;
                     end else begin
                        mode_in      = acq_pkg::M_RUNNING;
                        o_stat_valid = 1'b1;
                     end
                  end
                  acq_pkg::K_TIMED: begin
                     if (mode_ff != acq_pkg::M_ARMED || waiting_ff) begin
                        o_stat_valid = 1'b1;
                        o_status     = acq_pkg::ST_INVALID;
                     end else if (start_diff[31]) begin
                        o_stat_valid = 1'b1;
                        o_status     = acq_pkg::ST_EXPIRED;
                     end else begin
                        waiting_in = 1'b1;
                        target_in  = req_ch.target_tick;
                     end
                  end
                  acq_pkg::K_CLEAR: begin
                     o_stat_valid = 1'b1;
                     if (mode_ff == acq_pkg::M_RUNNING) begin
                        o_status = acq_pkg::ST_INVALID;
                     end else begin
                        rd_ptr_in = '0;
                        wr_ptr_in = '0;
                        count_in  = '0;
                        if (!(mode_ff inside {acq_pkg::M_FAULT, acq_pkg::M_ESTOP})) begin
                           mode_in = acq_pkg::M_IDLE;
                        end
                     end
                  end
                  acq_pkg::K_ESTOP: begin
                     rd_ptr_in   = '0;
                     wr_ptr_in   = '0;
                     count_in    = '0;
                     mode_in     = acq_pkg::M_ESTOP;
                     o_cmd_valid = 1'b1;
                     o_hard      = 1'b1;
                  end
                  acq_pkg::K_CLR_FAULT: begin
                     o_stat_valid = 1'b1;
                     if (!(mode_ff inside {acq_pkg::M_FAULT, acq_pkg::M_ESTOP})) begin
                        o_status = acq_pkg::ST_INVALID;
                     end else begin
                        rd_ptr_in = '0;
                        wr_ptr_in = '0;
                        count_in  = '0;
                        mode_in   = acq_pkg::M_IDLE;
                     end
                  end
                  acq_pkg::K_DONE: begin
                     if (mode_ff == acq_pkg::M_RUNNING) begin
                        mode_in = acq_pkg::M_IDLE;
                     end
                  end
                  acq_pkg::K_FAULT: begin
                     mode_in = acq_pkg::M_FAULT;
                  end
                  acq_pkg::K_TICK: begin
                     if (waiting_ff && due) begin
                        waiting_in = 1'b0;
                        if (mode_ff != acq_pkg::M_ARMED) begin
                           o_stat_valid = 1'b1;
                           o_status     = acq_pkg::ST_INVALID;
                        end else if (count_ff != '0) begin
                           o_load      = 1'b0;
                           state_in    = S_FLUSH;
                           store_rd.en = 1'b1;
                        end else begin
                           mode_in      = acq_pkg::M_RUNNING;
                           o_stat_valid = 1'b1;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_FLUSH: begin
            // read data for rd_ptr_ff is in the store output register
            if (load) begin
               o_load      = 1'b1;
               o_cmd_valid = 1'b1;
               o_cmd       = 64'(store_data);
               o_last      = 1'b0;
               rd_ptr_in   = ptr_next(rd_ptr_ff);
               count_in    = count_ff - 1'b1;
               if (count_ff > acq_pkg::COUNT_BITS'(1)) begin
                  store_rd.en   = 1'b1;
                  store_rd.addr = ptr_next(rd_ptr_ff);
               end else begin
                  state_in = S_STATUS;
               end
            end
         end
         S_STATUS: begin
            if (load) begin
               o_load       = 1'b1;
               o_stat_valid = 1'b1;
               mode_in      = acq_pkg::M_RUNNING;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // result register
      rsp_valid_in      = rsp_valid_ff && !rsp_ch.ready;
      rsp_cmd_valid_in  = rsp_cmd_valid_ff;
      rsp_cmd_in        = rsp_cmd_ff;
      rsp_hard_in       = rsp_hard_ff;
      rsp_stat_valid_in = rsp_stat_valid_ff;
      rsp_status_in     = rsp_status_ff;
      rsp_mode_in       = rsp_mode_ff;
      rsp_count_in      = rsp_count_ff;
      rsp_last_in       = rsp_last_ff;
      if (o_load) begin
         rsp_valid_in      = 1'b1;
         rsp_cmd_valid_in  = o_cmd_valid;
         rsp_cmd_in        = o_cmd;
         rsp_hard_in       = o_hard;
         rsp_stat_valid_in = o_stat_valid;
         rsp_status_in     = o_stat_valid ? o_status : acq_pkg::ST_OK;
         rsp_mode_in       = mode_in;
         rsp_count_in      = 5'(count_in);
         rsp_last_in       = o_last;
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= acq_pkg::M_IDLE;
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         count_ff     <= '0;
         waiting_ff   <= 1'b0;
         target_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         rd_ptr_ff    <= rd_ptr_in;
         wr_ptr_ff    <= wr_ptr_in;
         count_ff     <= count_in;
         waiting_ff   <= waiting_in;
         target_ff    <= target_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_cmd_valid_ff  <= rsp_cmd_valid_in;
      rsp_cmd_ff        <= rsp_cmd_in;
      rsp_hard_ff       <= rsp_hard_in;
      rsp_stat_valid_ff <= rsp_stat_valid_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_mode_ff       <= rsp_mode_in;
      rsp_count_ff      <= rsp_count_in;
      rsp_last_ff       <= rsp_last_in;
   end

   // result channel
   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.command_valid    = rsp_cmd_valid_ff;
   assign rsp_ch.command_out      = rsp_cmd_ff;
   assign rsp_ch.hard_stop        = rsp_hard_ff;
   assign rsp_ch.status_valid     = rsp_stat_valid_ff;
   assign rsp_ch.status           = rsp_status_ff;
   assign rsp_ch.controller_state = rsp_mode_ff;
   assign rsp_ch.queue_count      = rsp_count_ff;
   assign rsp_ch.last             = rsp_last_ff;

   // pending count never passes the queue depth
   assert property (@(posedge clock) disable iff (reset) count_ff <= FullCount)
      else $error("pending count above queue depth");

   // armed between requests always has something to flush
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && mode_ff == acq_pkg::M_ARMED) |-> (count_ff != '0))
      else $error("armed with an empty queue");

   // a flush runs only from armed and never on an empty queue
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FLUSH) |-> (mode_ff == acq_pkg::M_ARMED && count_ff != '0))
      else $error("flush outside armed or with empty queue");

   // the flush ends with the ok status that enters running
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_STATUS && load) |=>
         (rsp_valid_ff && rsp_last_ff && rsp_mode_ff == acq_pkg::M_RUNNING))
      else $error("flush not closed by running status");

endmodule

// ===== tb/sv/tb.sv =====
// one result as seen on the response channel
typedef struct {
   logic                             command_valid;
   logic [acq_pkg::COMMAND_BITS-1:0] command_out;
   logic                             hard_stop;
   logic                             status_valid;
   acq_pkg::status_type              status;
   acq_pkg::mode_type                controller_state;
   logic [acq_pkg::COUNT_BITS-1:0]   queue_count;
   logic                             last;
} motor_result_type;

// tracks the controller and the queue, and holds the results still owed
class motor_queue_scoreboard;
   logic [acq_pkg::COMMAND_BITS-1:0] command_store [acq_pkg::QUEUE_DEPTH];
   logic [acq_pkg::PTR_BITS-1:0]     rd_ptr;
   logic [acq_pkg::PTR_BITS-1:0]     wr_ptr;
   logic [acq_pkg::COUNT_BITS-1:0]   pending;
   acq_pkg::mode_type                mode;
   bit                               start_waiting;
   logic [31:0]                      start_target;
   motor_result_type                 step_results[$];
   motor_result_type                 expected_results[$];
   int unsigned                      failures;

   function new();
      rd_ptr        = '0;
      wr_ptr        = '0;
      pending       = '0;
      mode          = acq_pkg::M_IDLE;
      start_waiting = 1'b0;
      start_target  = '0;
      failures      = 0;
   endfunction

   function int unsigned outstanding();
      return expected_results.size();
   endfunction

   // one result of the current request, tagged with mode and count as they stand now
   function void emit_result(logic cv, logic [acq_pkg::COMMAND_BITS-1:0] cmd, logic hs,
                             logic sv, acq_pkg::status_type st);
      motor_result_type r;
      r.command_valid    = cv;
      r.command_out      = cmd;
      r.hard_stop        = hs;
      r.status_valid     = sv;
      r.status           = st;
      r.controller_state = mode;
      r.queue_count      = pending;
      r.last             = 1'b0;
      step_results.push_back(r);
   endfunction

   function void empty_queue();
      rd_ptr  = '0;
      wr_ptr  = '0;
      pending = '0;
   endfunction

   // every queued command goes out in order
   function void flush_queue();
      logic [acq_pkg::COMMAND_BITS-1:0] word;
      while (pending > 0) begin
         word    = command_store[rd_ptr];
         rd_ptr  = rd_ptr + 1'b1;
         pending = pending - 1'b1;
         emit_result(1'b1, word, 1'b0, 1'b0, acq_pkg::ST_OK);
      end
   endfunction

   // work out the results of one accepted request
   function void note_request(logic [3:0] kind, logic [63:0] word, logic [31:0] target,
                              logic [31:0] now);
      logic [31:0]      lead;
      motor_result_type r;
      step_results.delete();
      case (kind)
         acq_pkg::K_QUEUE: begin
            if (mode != acq_pkg::M_IDLE) begin
               emit_result(1'b0, '0, 1'b0, 1'b1, acq_pkg::ST_INVALID);
            end else if (pending >= acq_pkg::QUEUE_DEPTH) begin
               emit_result(1'b0, '0, 1'b0, 1'b1, acq_pkg::ST_FULL);
            end else begin
               command_store[wr_ptr] = word[acq_pkg::COMMAND_BITS-1:0];
               wr_ptr  = wr_ptr + 1'b1;
               pending = pending + 1'b1;
               emit_result(1'b0, '0, 1'b0, 1'b1, acq_pkg::ST_OK);
            end
         end
         acq_pkg::K_ARM: begin
            if (mode != acq_pkg::M_IDLE) begin
               emit_result(1'b0, '0, 1'b0, 1'b1, acq_pkg::ST_INVALID);
            end else if (pending == 0) begin
               emit_result(1'b0, '0, 1'b0, 1'b1, acq_pkg::ST_EMPTY);
            end else begin
               mode = acq_pkg::M_ARMED;
               emit_result(1'b0, '0, 1'b0, 1'b1, acq_pkg::ST_OK);
            end
         end
         acq_pkg::K_START: begin
            if (mode != acq_pkg::M_ARMED) begin
               emit_result(1'b0, '0, 1'b0, 1'b1, acq_pkg::ST_INVALID);
            end else begin
               flush_queue();
               mode = acq_pkg::M_RUNNING;
               emit_result(1'b0, '0, 1'b0, 1'b1, acq_pkg::ST_OK);
            end
         end
         acq_pkg::K_TIMED: begin
            lead = target - now;
            if (mode != acq_pkg::M_ARMED || start_waiting) begin
               emit_result(1'b0, '0, 1'b0, 1'b1, acq_pkg::ST_INVALID);
            end else if (lead[31]) begin
               emit_result(1'b0, '0, 1'b0, 1'b1, acq_pkg::ST_EXPIRED);
            end else begin
               start_waiting = 1'b1;
               start_target  = target;
               emit_result(1'b0, '0, 1'b0, 1'b0, acq_pkg::ST_OK);
            end
         end
         acq_pkg::K_CLEAR: begin
            if (mode == acq_pkg::M_RUNNING) begin
               emit_result(1'b0, '0, 1'b0, 1'b1, acq_pkg::ST_INVALID);
            end else begin
               empty_queue();
               if (mode != acq_pkg::M_FAULT && mode != acq_pkg::M_ESTOP)
                  mode = acq_pkg::M_IDLE;
               emit_result(1'b0, '0, 1'b0, 1'b1, acq_pkg::ST_OK);
            end
         end
         acq_pkg::K_ESTOP: begin
            empty_queue();
            mode = acq_pkg::M_ESTOP;
            emit_result(1'b1, '0, 1'b1, 1'b0, acq_pkg::ST_OK);
         end
         acq_pkg::K_CLR_FAULT: begin
            if (mode != acq_pkg::M_FAULT && mode != acq_pkg::M_ESTOP) begin
               emit_result(1'b0, '0, 1'b0, 1'b1, acq_pkg::ST_INVALID);
            end else begin
               empty_queue();
               mode = acq_pkg::M_IDLE;
               emit_result(1'b0, '0, 1'b0, 1'b1, acq_pkg::ST_OK);
            end
         end
         acq_pkg::K_DONE: begin
            if (mode == acq_pkg::M_RUNNING) mode = acq_pkg::M_IDLE;
            emit_result(1'b0, '0, 1'b0, 1'b0, acq_pkg::ST_OK);
         end
         acq_pkg::K_FAULT: begin
            mode = acq_pkg::M_FAULT;
            emit_result(1'b0, '0, 1'b0, 1'b0, acq_pkg::ST_OK);
         end
         acq_pkg::K_TICK: begin
            lead = start_target - now;
            if (start_waiting && (lead == 0 || lead[31])) begin
               // the timed start is due
               start_waiting = 1'b0;
               if (mode == acq_pkg::M_ARMED) begin
                  flush_queue();
                  mode = acq_pkg::M_RUNNING;
                  emit_result(1'b0, '0, 1'b0, 1'b1, acq_pkg::ST_OK);
               end else begin
                  emit_result(1'b0, '0, 1'b0, 1'b1, acq_pkg::ST_INVALID);
               end
            end else begin
               emit_result(1'b0, '0, 1'b0, 1'b0, acq_pkg::ST_OK);
            end
         end
         default: begin
            emit_result(1'b0, '0, 1'b0, 1'b0, acq_pkg::ST_OK);
         end
      endcase
      // only the final result of the request carries last
      foreach (step_results[i]) begin
         r      = step_results[i];
         r.last = (i == step_results.size() - 1);
         expected_results.push_back(r);
      end
   endfunction

   function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         failures++;
      end
   endfunction

   // compare one accepted result with the oldest one owed
   function void check_result(motor_result_type seen);
      motor_result_type want;
      if (expected_results.size() == 0) begin
         $error("result with no request behind it: command_out %0h status %0d",
                seen.command_out, seen.status);
         failures++;
         return;
      end
      want = expected_results.pop_front();
      compare_field("command_valid", want.command_valid, seen.command_valid);
      compare_field("command_out", want.command_out, seen.command_out);
      compare_field("hard_stop", want.hard_stop, seen.hard_stop);
      compare_field("status_valid", want.status_valid, seen.status_valid);
      compare_field("status", want.status, seen.status);
      compare_field("controller_state", want.controller_state, seen.controller_state);
      compare_field("queue_count", want.queue_count, seen.queue_count);
      compare_field("last", want.last, seen.last);
   endfunction
endclass

module tb;
   localparam logic [3:0] KIND_UNUSED = 4'hF;
   localparam int unsigned DIRECTED_ITEMS = 25;
   localparam int unsigned RANDOM_ITEMS   = 220;

   logic clock;
   logic reset;
   bit   calm_stretch;
   int unsigned items_sent;
   motor_queue_scoreboard board;

   acq_req_if req_ch ();
   acq_rsp_if rsp_ch ();

   armed_command_queue_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard limit on run time
   initial begin
      #50_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // idle lengths: mostly none or short, a few long
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (calm_stretch || roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(30, 80);
   endfunction

   function automatic logic [63:0] any_word();
      return {$urandom(), $urandom()};
   endfunction

   // response side stalls
   initial begin
      int unsigned hold;
      rsp_ch.ready = 1'b0;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         rsp_ch.ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         hold = pick_gap();
         if (hold > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
      end
   end

   // watch both channels
   always @(posedge clock) begin
      motor_result_type seen;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            board.note_request(req_ch.kind, req_ch.command_word, req_ch.target_tick,
                               req_ch.now_tick);
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen.command_valid    = rsp_ch.command_valid;
            seen.command_out      = rsp_ch.command_out;
            seen.hard_stop        = rsp_ch.hard_stop;
            seen.status_valid     = rsp_ch.status_valid;
            seen.status           = acq_pkg::status_type'(rsp_ch.status);
            seen.controller_state = acq_pkg::mode_type'(rsp_ch.controller_state);
            seen.queue_count      = rsp_ch.queue_count;
            seen.last             = rsp_ch.last;
            board.check_result(seen);
         end
      end
   end

   // drive one request and hold it until taken
   task automatic send_request(logic [3:0] kind, logic [63:0] word, logic [31:0] target,
                               logic [31:0] now);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid        <= 1'b0;
         req_ch.kind         <= 4'($urandom());
         req_ch.command_word <= any_word();
         repeat (gap) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.kind         <= kind;
      req_ch.command_word <= word;
      req_ch.target_tick  <= target;
      req_ch.now_tick     <= now;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      items_sent++;
   endtask

   // stop sending until every owed result is back
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (board.outstanding() != 0);
   endtask

   // a random request of any kind, now and then
   task automatic maybe_noise(inout bit upset);
      if ($urandom_range(0, 19) == 0) begin
         send_request(4'($urandom_range(0, 15)), any_word(), $urandom(), $urandom());
         upset = 1'b1;
      end
   endtask

   // queue, arm, start or timed start, finish; with the odd disruption
   task automatic run_motion_cycle();
      int unsigned depth;
      int unsigned path;
      logic [31:0] now;
      logic [31:0] target;
      bit          upset;
      upset = 1'b0;
      if ($urandom_range(0, 9) == 0) depth = acq_pkg::QUEUE_DEPTH + $urandom_range(0, 2);
      else depth = $urandom_range(1, 5);
      repeat (depth) begin
         send_request(acq_pkg::K_QUEUE, any_word(), $urandom(), $urandom());
         maybe_noise(upset);
      end
      if ($urandom_range(0, 9) != 0)
         send_request(acq_pkg::K_ARM, any_word(), $urandom(), $urandom());
      path = $urandom_range(0, 9);
      if (path < 4) begin
         send_request(acq_pkg::K_START, any_word(), $urandom(), $urandom());
      end else if (path < 8) begin
         // timed start, then ticks until it is due
         now    = $urandom();
         target = now + $urandom_range(0, 24);
         send_request(acq_pkg::K_TIMED, any_word(), target, now);
         do begin
            now = now + $urandom_range(1, 6);
            if ($urandom_range(0, 11) == 0) begin
               case ($urandom_range(0, 3))
                  0: send_request(acq_pkg::K_START, any_word(), $urandom(), now);
                  1: send_request(acq_pkg::K_CLEAR, any_word(), $urandom(), now);
                  2: send_request(acq_pkg::K_FAULT, any_word(), $urandom(), now);
                  default: send_request(acq_pkg::K_TIMED, any_word(), target, now);
               endcase
               upset = 1'b1;
            end
            send_request(acq_pkg::K_TICK, any_word(), $urandom(), now);
         end while ($signed(target - now) > 0);
      end else if (path == 8) begin
         // target already behind us
         now = $urandom();
         send_request(acq_pkg::K_TIMED, any_word(), now - $urandom_range(1, 5000), now);
         send_request(acq_pkg::K_START, any_word(), $urandom(), $urandom());
      end else begin
         send_request($urandom_range(0, 1) ? acq_pkg::K_ESTOP : acq_pkg::K_FAULT,
                      any_word(), $urandom(), $urandom());
         upset = 1'b1;
      end
      send_request(acq_pkg::K_DONE, any_word(), $urandom(), $urandom());
      if (upset) begin
         send_request(acq_pkg::K_CLR_FAULT, any_word(), $urandom(), $urandom());
         send_request(acq_pkg::K_CLEAR, any_word(), $urandom(), $urandom());
      end
   endtask

   // reset, directed requests, then random motion cycles
   initial begin
      bit drained_mid;
      board               = new();
      reset               = 1'b1;
      calm_stretch        = 1'b0;
      items_sent          = 0;
      drained_mid         = 1'b0;
      req_ch.valid        = 1'b0;
      req_ch.kind         = '0;
      req_ch.command_word = '0;
      req_ch.target_tick  = '0;
      req_ch.now_tick     = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // arm on an empty queue, unknown kind, fault clear with no fault
      send_request(acq_pkg::K_ARM, '0, '0, '0);
      send_request(KIND_UNUSED, '1, '1, '1);
      send_request(acq_pkg::K_CLR_FAULT, '0, '0, '0);
      // extreme command words
      send_request(acq_pkg::K_QUEUE, 64'h0, '0, '0);
      send_request(acq_pkg::K_QUEUE, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0);
      send_request(acq_pkg::K_QUEUE, 64'hA5A5_5A5A_0F0F_F0F0, '0, '0);
      send_request(acq_pkg::K_DONE, '0, '0, '0);
      send_request(acq_pkg::K_ARM, '0, '0, '0);
      send_request(acq_pkg::K_QUEUE, any_word(), '0, '0);
      // timed start: expired, waiting at the far edge, second one refused
      send_request(acq_pkg::K_TIMED, '0, 32'h0000_0000, 32'h0000_0001);
      send_request(acq_pkg::K_TIMED, '0, 32'hFFFF_FFFF, 32'h8000_0000);
      send_request(acq_pkg::K_TIMED, '0, 32'hFFFF_FFFF, 32'h8000_0000);
      send_request(acq_pkg::K_TICK, '0, '0, 32'h8000_0001);
      // plain start while the timed one waits, then it fires while running
      send_request(acq_pkg::K_START, '0, '0, '0);
      send_request(acq_pkg::K_CLEAR, '0, '0, '0);
      send_request(acq_pkg::K_TICK, '0, '0, 32'hFFFF_FFFF);
      send_request(acq_pkg::K_DONE, '0, '0, '0);
      // clear while a timed start waits, then fault, estop and the late firing
      send_request(acq_pkg::K_QUEUE, any_word(), '0, '0);
      send_request(acq_pkg::K_ARM, '0, '0, '0);
      send_request(acq_pkg::K_TIMED, '0, 32'h0000_0005, 32'hFFFF_FFF0);
      send_request(acq_pkg::K_CLEAR, '0, '0, '0);
      send_request(acq_pkg::K_FAULT, '0, '0, '0);
      send_request(acq_pkg::K_ESTOP, '0, '0, '0);
      send_request(acq_pkg::K_TICK, '0, '0, 32'd100);
      send_request(acq_pkg::K_CLR_FAULT, '0, '0, '0);
      drain_results();

      while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
         calm_stretch = (items_sent >= 80 && items_sent < 130);
         if (!drained_mid && items_sent >= 160) begin
            drain_results();
            drained_mid = 1'b1;
         end
         run_motion_cycle();
      end
      calm_stretch = 1'b0;

      drain_results();
      repeat (40) @(posedge clock);
      if (board.failures == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
